### hdl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the unsorted-array max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Default number of entries the queue can hold
  localparam int unsigned CAPACITY = 128;

  // Request kinds (code 3 is unused and treated as a no-op)
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Input beat
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_t;

  // Output beat
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
  } out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT_INIT,
    ST_SHIFT,
    ST_RESP
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;       // capture the input beat
    logic exec;        // insert / error checks, clear result
    logic scan;        // stream entries through the max compare
    logic shift_init;  // point the read pointer past the maximum
    logic shift;       // move later entries down one place
    logic dec;         // one entry removed
    logic load;        // move result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_scan;   // find/delete on a non-empty queue
    logic is_delete;
    logic last;        // data for the last stored entry is arriving
    logic shift_none;  // the maximum is the last entry
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

### hdl/max_priority_queue_unsorted.sv
// Insert, no-op kind and error cases go from accept through execute to the result.
// Find-max streams one RAM read per stored entry through the compare.
// Delete-max adds a shift-init step and, when later entries exist, moves them
// down the RAM; one request is in work at a time.
// A finished result waits in the output register while the next request is accepted.
// Reset clears the count and control state; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
// max_priority_queue_unsorted
// Max priority queue kept as an unsorted array with insert, delete-max, find-max.
// ----------------------------------------------------------------------------
module max_priority_queue_unsorted #(
  parameter int unsigned CAPACITY = mpq_pkg::CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mpq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mpq_pkg::out_t out_data_o
);

  mpq_pkg::cmd_t cmd;
  mpq_pkg::sts_t sts;

  // Sequencer
  mpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and compare
  mpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/mpq_dp.sv
// ----------------------------------------------------------------------------
// mpq_dp
// Datapath: entry RAM, count, read pointer, running maximum and output register.
// ----------------------------------------------------------------------------
module mpq_dp #(
  parameter int unsigned CAPACITY = mpq_pkg::CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mpq_pkg::in_t  in_data_i,
  input  mpq_pkg::cmd_t cmd_i,
  output mpq_pkg::sts_t sts_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output mpq_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [1:0]         kind_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_tag_q;
  logic signed [31:0] res_q, res_d;
  logic [AW-1:0]      best_idx_q, best_idx_d;
  logic [1:0]         status_q, status_d;
  logic               out_valid_q, out_valid_d;
  mpq_pkg::out_t      out_q;

  logic               full;
  logic               empty;
  logic               is_insert;
  logic               is_search;
  logic [AW-1:0]      last_idx;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic [31:0]        rd_data;
  logic               out_free;

  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign is_insert = (kind_q == mpq_pkg::KIND_INSERT);
  assign is_search = (kind_q == mpq_pkg::KIND_DELETE) || (kind_q == mpq_pkg::KIND_FIND);
  assign last_idx  = AW'(count_q - CW'(1));
  assign out_free  = !out_valid_q || !out_stall_i;

  // Read one stored entry per cycle while scanning or shifting
  assign rd_en = (cmd_i.scan || cmd_i.shift) && (ptr_q < count_q);

  // Insert writes at the tail; shift writes each entry one place lower
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_tag_q - AW'(1);
    wr_data = rd_data;
    if (cmd_i.exec && is_insert && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_data = value_q;
    end else if (cmd_i.shift && rd_vld_q) begin
      wr_en = 1'b1;
    end
  end

  mpq_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Request payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= in_data_i.kind;
      value_q <= in_data_i.value;
    end
  end

  // Count and read pointer
  always_comb begin
    count_d = count_q;
    if (cmd_i.exec && is_insert && !full) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CW'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.exec) begin
      ptr_d = '0;
    end else if (cmd_i.shift_init) begin
      ptr_d = CW'(best_idx_q) + CW'(1);
    end else if (rd_en) begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  // Status, result and running maximum (first of equal values wins)
  always_comb begin
    res_d      = res_q;
    best_idx_d = best_idx_q;
    status_d   = status_q;
    if (cmd_i.exec) begin
      res_d    = '0;
      status_d = mpq_pkg::STATUS_OK;
      if (is_insert && full) begin
        status_d = mpq_pkg::STATUS_FULL;
      end else if (is_search && empty) begin
        status_d = mpq_pkg::STATUS_EMPTY;
      end
    end else if (cmd_i.scan && rd_vld_q) begin
      if (rd_tag_q == '0 || $signed(rd_data) > res_q) begin
        res_d      = $signed(rd_data);
        best_idx_d = rd_tag_q;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q   <= ptr_q[AW-1:0];
    res_q      <= res_d;
    best_idx_q <= best_idx_d;
    status_q   <= status_d;
    if (cmd_i.load) begin
      out_q.result_value <= res_q;
      out_q.status       <= status_q;
      out_q.entry_count  <= 8'(count_q);
    end
  end

  assign sts_o.need_scan  = is_search && !empty;
  assign sts_o.is_delete  = (kind_q == mpq_pkg::KIND_DELETE);
  assign sts_o.last       = rd_vld_q && (rd_tag_q == last_idx);
  assign sts_o.shift_none = (best_idx_q == last_idx);
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // Count never exceeds the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Reads never go past the last stored entry
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (ptr_q < count_q))
    else $error("read past last stored entry");

  // A full status is reported only with the queue at capacity
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && (status_q == mpq_pkg::STATUS_FULL) |-> full)
    else $error("full status with free room");

  // Removing an entry needs a non-empty queue
  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dec |-> !empty)
    else $error("decrement of empty queue");
`endif

endmodule

### hdl/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Controller: sequences accept, execute, scan, shift and result load.
// ----------------------------------------------------------------------------
module mpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mpq_pkg::sts_t sts_i,
  output mpq_pkg::cmd_t cmd_o
);

  mpq_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mpq_pkg::ST_EXEC;
      end
      mpq_pkg::ST_EXEC: begin
        state_d = sts_i.need_scan ? mpq_pkg::ST_SCAN : mpq_pkg::ST_RESP;
      end
      mpq_pkg::ST_SCAN: begin
        if (sts_i.last) begin
          state_d = sts_i.is_delete ? mpq_pkg::ST_SHIFT_INIT : mpq_pkg::ST_RESP;
        end
      end
      mpq_pkg::ST_SHIFT_INIT: begin
        state_d = sts_i.shift_none ? mpq_pkg::ST_RESP : mpq_pkg::ST_SHIFT;
      end
      mpq_pkg::ST_SHIFT: begin
        if (sts_i.last) state_d = mpq_pkg::ST_RESP;
      end
      mpq_pkg::ST_RESP: begin
        if (sts_i.out_free) state_d = mpq_pkg::ST_IDLE;
      end
      default: state_d = mpq_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mpq_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      mpq_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      mpq_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      mpq_pkg::ST_SHIFT_INIT: begin
        cmd_o.shift_init = 1'b1;
        cmd_o.dec        = sts_i.shift_none;
      end
      mpq_pkg::ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.dec   = sts_i.last;
      end
      mpq_pkg::ST_RESP: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // An accepted beat is always followed by the execute step
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == mpq_pkg::ST_EXEC)
    else $error("accepted beat not executed");
`endif

endmodule
